### rtl/tmcc_pkg.sv
// ============================================================================
// tmcc_pkg
// Shared types and constants of the thresholded map cross-correlation unit.
// ============================================================================
package tmcc_pkg;

    localparam int VAL_W    = 16;   // Q4.12 voxel values
    localparam int PROD_W   = 32;   // Q8.24 voxel product
    localparam int SUM_W    = 64;   // Q40.24 running sum
    localparam int COUNT_W  = 25;   // voxel index and counts
    localparam int OFFS_W   = 26;   // index offset
    localparam int CORR_W   = 32;   // Q2.30 result
    localparam int STATUS_W = 2;
    localparam int NM_W     = 58;   // count times mean product, signed
    localparam int NRMS_W   = 57;   // count times rms product, unsigned
    localparam int FRAC_SH  = 30;   // Q.24 over Q.24 to Q2.30
    localparam int DVD_W    = SUM_W + FRAC_SH;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_PRODUCT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_PRODUCT  = 3'd6;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV = 2'd2;

    localparam logic [COUNT_W-1:0] VOXEL_COUNT_RST = 25'd16777216;

    typedef struct packed {
        logic signed [VAL_W-1:0] model_value;
        logic signed [VAL_W-1:0] ref_value;
        logic                    last_voxel;
    } in_word_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [COUNT_W-1:0]       used_voxels;
        logic [STATUS_W-1:0]      status;
    } out_word_t;

    // classified voxel travelling from front to back
    typedef struct packed {
        logic                     take;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } q_entry_t;

    // normalisation settings seen by the back end
    typedef struct packed {
        logic signed [SUM_W-1:0]  norm_offset;
        logic signed [SUM_W-1:0]  norm_scale;
        logic signed [PROD_W-1:0] mean_product;
        logic [PROD_W-1:0]        rms_product;
        logic [COUNT_W-1:0]       n_eff;
    } norm_cfg_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [CORR_W-1:0] corr;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_SEL,
        ST_DIV,
        ST_FIN
    } back_state_t;

endpackage

### rtl/tmcc_front.sv
// ============================================================================
// tmcc_front
// Accepts voxel pairs, tracks the voxel index, applies threshold and bounds.
// ============================================================================
module tmcc_front
    import tmcc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_word_t                 in_data,
    input  logic signed [VAL_W-1:0]  threshold,
    input  logic signed [OFFS_W-1:0] index_offset,
    input  logic [COUNT_W-1:0]       n_eff,
    input  logic                     q_full,
    output logic                     push,
    output q_entry_t                 push_entry
);

    logic [COUNT_W-1:0]       index_reg;
    logic [COUNT_W-1:0]       index_next;
    logic signed [COUNT_W+1:0] shifted;
    logic signed [COUNT_W+1:0] n_ext;
    logic                     take;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign shifted = $signed({2'b00, index_reg}) + $signed({index_offset[OFFS_W-1], index_offset});
    assign n_ext   = $signed({2'b00, n_eff});

    assign take = (in_data.model_value > threshold) && (index_reg < n_eff)
                  && !shifted[COUNT_W+1] && (shifted < n_ext);

    always_comb
    begin
        push_entry.take    = take;
        push_entry.product = $signed(in_data.model_value) * $signed(in_data.ref_value);
        push_entry.last    = in_data.last_voxel;
    end

    // index saturates; cleared after the last voxel of a map
    always_comb
    begin
        index_next = index_reg;
        if (push)
        begin
            if (in_data.last_voxel)
                index_next = '0;
            else if (index_reg != '1)
                index_next = index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= '0;
        else
            index_reg <= index_next;
    end

endmodule

### rtl/tmcc_queue.sv
// ============================================================================
// tmcc_queue
// Short queue of classified voxels between front and back.
// ============================================================================
module tmcc_queue
    import tmcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     full,
    output logic     empty
);

    q_entry_t            mem_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(Q_DEPTH))
        else $error("queue count past depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

endmodule

### rtl/tmcc_div.sv
// ============================================================================
// tmcc_div
// Restoring divider, one quotient bit per cycle, saturating signed Q2.30 out.
// ============================================================================
module tmcc_div
    import tmcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]   den_reg, den_next;
    logic [CORR_W:0]    quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [SUM_W-1:0]   trial;
    logic               ge;
    logic [CORR_W:0]    limit;
    logic [CORR_W:0]    quo_sat;

    // remainder stays below the divisor (< 2^63), so one shifted bit fits
    assign trial = {rem_reg[SUM_W-2:0], dvd_reg[DVD_W-1]};
    assign ge    = (trial >= den_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS - 1);
            dvd_next  = {req.mag, {FRAC_SH{1'b0}}};
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = '0;
            ovf_next  = 1'b0;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = ge ? trial - den_reg : trial;
            quo_next = {quo_reg[CORR_W-1:0], ge};
            ovf_next = ovf_reg | quo_reg[CORR_W];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
    end

    // saturate to 2^31 for negative, 2^31-1 for positive, then apply sign
    assign limit   = neg_reg ? {2'b01, {(CORR_W-1){1'b0}}} : {2'b00, {(CORR_W-1){1'b1}}};
    assign quo_sat = (ovf_reg || (quo_reg > limit)) ? limit : quo_reg;

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.corr = neg_reg ? CORR_W'(0) - quo_sat[CORR_W-1:0] : quo_sat[CORR_W-1:0];
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

### rtl/tmcc_back.sv
// ============================================================================
// tmcc_back
// Accumulates classified voxels and normalises the sum at the end of a map.
// ============================================================================
module tmcc_back
    import tmcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  q_entry_t  q_entry,
    output logic      pop,
    input  norm_cfg_t cfg,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    back_state_t              state_reg, state_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [NM_W-1:0]   nm_reg, nm_next;
    logic [NRMS_W-1:0]        nrms_reg, nrms_next;
    logic [CORR_W-1:0]        corr_reg, corr_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_data_reg, out_data_next;

    logic                     use_norm;
    logic signed [SUM_W-1:0]  nm_ext;
    logic                     neg_n, neg_m;
    logic [SUM_W-1:0]         mag_n, mag_m;

    assign use_norm = (cfg.norm_offset > 0) && (cfg.norm_scale > 0);
    assign nm_ext   = {{(SUM_W-NM_W){nm_reg[NM_W-1]}}, nm_reg};
    assign neg_n    = sum_reg < cfg.norm_offset;
    assign mag_n    = neg_n ? cfg.norm_offset - sum_reg : sum_reg - cfg.norm_offset;
    assign neg_m    = sum_reg < nm_ext;
    assign mag_m    = neg_m ? nm_ext - sum_reg : sum_reg - nm_ext;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        nm_next        = nm_reg;
        nrms_next      = nrms_reg;
        corr_next      = corr_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        div_req        = '0;
        case (state_reg)
            ST_ACC:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (q_entry.take)
                    begin
                        sum_next = sum_reg + {{(SUM_W-PROD_W){q_entry.product[PROD_W-1]}},
                                              q_entry.product};
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_entry.last)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                nm_next    = $signed({1'b0, cfg.n_eff}) * cfg.mean_product;
                nrms_next  = cfg.n_eff * cfg.rms_product;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                corr_next = '0;
                if (cnt_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                    state_next  = ST_FIN;
                end
                else if (!use_norm && (nrms_reg == '0))
                begin
                    status_next = STATUS_ZERO_DIV;
                    state_next  = ST_FIN;
                end
                else
                begin
                    status_next   = STATUS_OK;
                    div_req.start = 1'b1;
                    div_req.neg   = use_norm ? neg_n : neg_m;
                    div_req.mag   = use_norm ? mag_n : mag_m;
                    div_req.den   = use_norm ? cfg.norm_scale : {{(SUM_W-NRMS_W){1'b0}}, nrms_reg};
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    corr_next  = div_rsp.corr;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.correlation = corr_reg;
                    out_data_next.used_voxels = cnt_reg;
                    out_data_next.status      = status_reg;
                    sum_next                  = '0;
                    cnt_next                  = '0;
                    state_next                = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg       <= nm_next;
        nrms_reg     <= nrms_next;
        corr_reg     <= corr_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_div_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && div_rsp.done |=> (state_reg == ST_FIN))
        else $error("divider result not taken");

endmodule

### rtl/thresholded_map_cross_correlation_unit.sv
// ============================================================================
// thresholded_map_cross_correlation_unit
// Result path: the last voxel word passes queue, accumulate, multiply, select,
//   divide (if due) and finish; other voxels give no result.
// Throughput: one voxel word per cycle in a map; a map end that divides holds
//   the back end for the 94-step divider; the 4-entry queue fills and stalls.
// Reset: config/control registers to defaults, sums/counts/index clear at once.
// ============================================================================
module thresholded_map_cross_correlation_unit
    import tmcc_pkg::*;
#(
    parameter int MAX_VOXELS = 16777216
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_VOXELS);

    // configuration registers
    logic signed [VAL_W-1:0]  threshold_reg;
    logic signed [OFFS_W-1:0] index_offset_reg;
    logic [COUNT_W-1:0]       voxel_count_reg;
    logic signed [SUM_W-1:0]  norm_offset_reg;
    logic signed [SUM_W-1:0]  norm_scale_reg;
    logic signed [PROD_W-1:0] mean_product_reg;
    logic [PROD_W-1:0]        rms_product_reg;

    logic [COUNT_W-1:0]       n_eff;
    norm_cfg_t                norm_cfg;
    logic                     q_push, q_pop, q_full, q_empty;
    q_entry_t                 q_in, q_out;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // writes always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            index_offset_reg <= '0;
            voxel_count_reg  <= VOXEL_COUNT_RST;
            norm_offset_reg  <= '0;
            norm_scale_reg   <= '0;
            mean_product_reg <= '0;
            rms_product_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[VAL_W-1:0];
                CFG_INDEX_OFFSET: index_offset_reg <= cfg_data[OFFS_W-1:0];
                CFG_VOXEL_COUNT:  voxel_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_NORM_OFFSET:  norm_offset_reg  <= cfg_data[SUM_W-1:0];
                CFG_NORM_SCALE:   norm_scale_reg   <= cfg_data[SUM_W-1:0];
                CFG_MEAN_PRODUCT: mean_product_reg <= cfg_data[PROD_W-1:0];
                CFG_RMS_PRODUCT:  rms_product_reg  <= cfg_data[PROD_W-1:0];
                default:          ;
            endcase
        end
    end

    // map size is clamped to the largest supported map
    assign n_eff = (voxel_count_reg > MAX_N) ? MAX_N : voxel_count_reg;

    always_comb
    begin
        norm_cfg.norm_offset  = norm_offset_reg;
        norm_cfg.norm_scale   = norm_scale_reg;
        norm_cfg.mean_product = mean_product_reg;
        norm_cfg.rms_product  = rms_product_reg;
        norm_cfg.n_eff        = n_eff;
    end

    // front: index tracking, threshold and bounds test, voxel product
    tmcc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .threshold    (threshold_reg),
        .index_offset (index_offset_reg),
        .n_eff        (n_eff),
        .q_full       (q_full),
        .push         (q_push),
        .push_entry   (q_in)
    );

    // decouples the streaming front from the stalling back end
    tmcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: accumulate, then normalise and hold the result word
    tmcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (q_out),
        .pop       (q_pop),
        .cfg       (norm_cfg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // serial divider for the back end, one quotient bit a cycle
    tmcc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule
